### design/ssq_pkg.sv
// Shared types and constants for the sorted sleep/wake-up queue.
// No dependencies; imported by ssq_cell, ssq_ctrl and the top level.
package ssq_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned WAKE_W  = TIME_W + 1;  // full sum, no wrap
  localparam int unsigned IDF_W   = 8;           // id field width on the buses
  localparam int unsigned IDX_W   = 16;          // widest supported stored id

  typedef enum logic {
    OP_SLEEP = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_WOKEN    = 2'd0,
    KIND_ACCEPTED = 2'd1,
    KIND_REJECTED = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    SH_HOLD   = 2'd0,
    SH_INSERT = 2'd1,
    SH_POP    = 2'd2
  } shift_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } state_e;

  // Controller outputs toward the datapath
  typedef struct packed {
    logic   s_ready;
    logic   load_out;   // write output register
    logic   sel_head;   // output id from head cell, else from request
    kind_e  kind;
    logic   last;
    logic   latch_now;  // capture tick time
    shift_e shift;
    state_e state;
  } ctrl_t;

endpackage

### design/ssq_cell.sv
// One queue slot: valid bit, wake time and sleeper id.
// Compares against the broadcast key; shifts from left on insert, from right on pop.
// Depends on ssq_pkg.
module ssq_cell
  import ssq_pkg::*;
#(
  parameter int unsigned ID_WIDTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  shift_e              shift_i,
  input  logic [WAKE_W-1:0]   key_i,
  input  logic [ID_WIDTH-1:0] new_id_i,
  input  logic                left_keep_i,
  input  logic                left_valid_i,
  input  logic [WAKE_W-1:0]   left_wake_i,
  input  logic [ID_WIDTH-1:0] left_id_i,
  input  logic                right_valid_i,
  input  logic [WAKE_W-1:0]   right_wake_i,
  input  logic [ID_WIDTH-1:0] right_id_i,
  output logic                valid_o,
  output logic [WAKE_W-1:0]   wake_o,
  output logic [ID_WIDTH-1:0] id_o,
  output logic                keep_o
);

  logic                valid_q, valid_d;
  logic [WAKE_W-1:0]   wake_q, wake_d;
  logic [ID_WIDTH-1:0] id_q, id_d;

  // valid entry due at or before key
  assign keep_o = valid_q && (wake_q <= key_i);

  always_comb begin
    valid_d = valid_q;
    wake_d  = wake_q;
    id_d    = id_q;
    unique case (shift_i)
      SH_HOLD: ;
      SH_INSERT: begin
        if (!keep_o) begin
          if (left_keep_i) begin
            valid_d = 1'b1;
            wake_d  = key_i;
            id_d    = new_id_i;
          end else begin
            valid_d = left_valid_i;
            wake_d  = left_wake_i;
            id_d    = left_id_i;
          end
        end
      end
      SH_POP: begin
        valid_d = right_valid_i;
        wake_d  = right_wake_i;
        id_d    = right_id_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wake_q <= wake_d;
    id_q   <= id_d;
  end

  assign valid_o = valid_q;
  assign wake_o  = wake_q;
  assign id_o    = id_q;

endmodule

### design/ssq_ctrl.sv
// Request sequencer: accepts sleep/tick requests and drains due sleepers.
// Depends on ssq_pkg.
module ssq_ctrl
  import ssq_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_valid_i,
  input  op_e   op_i,
  input  logic  full_i,
  input  logic  head_due_i,
  input  logic  next_due_i,
  input  logic  out_free_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i && out_free_i && (op_i == OP_TICK)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!head_due_i) begin
          state_d = ST_IDLE;
        end else if (out_free_i && !next_due_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o           = '0;
    ctrl_o.kind      = KIND_WOKEN;
    ctrl_o.shift     = SH_HOLD;
    ctrl_o.state     = state_q;
    unique case (state_q)
      ST_IDLE: begin
        ctrl_o.s_ready = out_free_i;
        if (s_valid_i && out_free_i) begin
          if (op_i == OP_SLEEP) begin
            ctrl_o.load_out = 1'b1;
            ctrl_o.last     = 1'b1;
            ctrl_o.kind     = full_i ? KIND_REJECTED : KIND_ACCEPTED;
            ctrl_o.shift    = full_i ? SH_HOLD : SH_INSERT;
          end else begin
            ctrl_o.latch_now = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (head_due_i && out_free_i) begin
          ctrl_o.load_out = 1'b1;
          ctrl_o.sel_head = 1'b1;
          ctrl_o.last     = !next_due_i;
          ctrl_o.shift    = SH_POP;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/sorted_sleep_wakeup_queue_top.sv
// Top level of the sorted sleep/wake-up queue: cell chain, sequencer, output register.
// Depends on ssq_pkg, ssq_cell, ssq_ctrl.
//
//  Channel   Dir  Accept                        Payload
//  s_axis    in   s_axis_tvalid & tready        tuser=operation, tdata=id/time/duration
//  m_axis    out  m_axis_tvalid & tready        tuser=result_kind, tdata=woken_id, tlast
//
// Sleep request: the wake time (current_time + sleep_duration, 33 bits) is inserted
// into the chain in the accept cycle unless the queue is full; the result is registered.
// Tick request: the tick time is latched on accept, then the sequencer drains due
// sleepers from the head; the chain shifts one slot toward the head per pop.
// Reset clears all slot valid bits and the sequencer; payload registers are not reset.
// Output stalls (m_axis_tready low) hold the result register and pause draining;
// no new request is taken while a tick drains.
module sorted_sleep_wakeup_queue_top
  import ssq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_WIDTH    = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // [7:0] sleeper_id, [39:8] current_time,
                                      // [71:40] sleep_duration
  input  logic        s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] woken_id
  output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
  output logic        m_axis_tlast    // last
);

  // request fields
  logic [IDF_W-1:0]    in_id;
  logic [TIME_W-1:0]   in_now;
  logic [TIME_W-1:0]   in_dur;
  logic [ID_WIDTH-1:0] new_id;
  logic [WAKE_W-1:0]   sleep_wake;
  op_e                 in_op;

  assign in_id      = s_axis_tdata[7:0];
  assign in_now     = s_axis_tdata[39:8];
  assign in_dur     = s_axis_tdata[71:40];
  assign in_op      = op_e'(s_axis_tuser);
  assign new_id     = ID_WIDTH'(IDX_W'(in_id));
  assign sleep_wake = {1'b0, in_now} + {1'b0, in_dur};

  // tick time held while draining
  logic [TIME_W-1:0] now_q;
  ctrl_t             ctrl;
  logic [WAKE_W-1:0] key;

  assign key = (ctrl.state == ST_DRAIN) ? {1'b0, now_q} : sleep_wake;

  always_ff @(posedge clk_i) begin
    if (ctrl.latch_now) begin
      now_q <= in_now;
    end
  end

  // cell chain, slot 0 is the head
  logic                valid_w [QUEUE_DEPTH];
  logic [WAKE_W-1:0]   wake_w  [QUEUE_DEPTH];
  logic [ID_WIDTH-1:0] id_w    [QUEUE_DEPTH];
  logic                keep_w  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] valid_vec;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                lk, lv, rv;
    logic [WAKE_W-1:0]   lw, rw;
    logic [ID_WIDTH-1:0] li, ri;

    if (i == 0) begin : g_head
      assign lk = 1'b1;
      assign lv = 1'b0;
      assign lw = '0;
      assign li = '0;
    end else begin : g_mid
      assign lk = keep_w[i-1];
      assign lv = valid_w[i-1];
      assign lw = wake_w[i-1];
      assign li = id_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign rv = 1'b0;
      assign rw = '0;
      assign ri = '0;
    end else begin : g_body
      assign rv = valid_w[i+1];
      assign rw = wake_w[i+1];
      assign ri = id_w[i+1];
    end

    ssq_cell #(
      .ID_WIDTH(ID_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .shift_i      (ctrl.shift),
      .key_i        (key),
      .new_id_i     (new_id),
      .left_keep_i  (lk),
      .left_valid_i (lv),
      .left_wake_i  (lw),
      .left_id_i    (li),
      .right_valid_i(rv),
      .right_wake_i (rw),
      .right_id_i   (ri),
      .valid_o      (valid_w[i]),
      .wake_o       (wake_w[i]),
      .id_o         (id_w[i]),
      .keep_o       (keep_w[i])
    );

    assign valid_vec[i] = valid_w[i];
  end

  // output register
  logic              m_valid_q;
  logic [IDF_W-1:0]  m_id_q;
  kind_e             m_kind_q;
  logic              m_last_q;
  logic              out_free;
  logic [IDF_W-1:0]  head_id;

  assign out_free = !m_valid_q || m_axis_tready;
  assign head_id  = IDF_W'(IDX_W'(id_w[0]));

  ssq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .op_i      (in_op),
    .full_i    (valid_w[QUEUE_DEPTH-1]),
    .head_due_i(keep_w[0]),
    .next_due_i(keep_w[1]),
    .out_free_i(out_free),
    .ctrl_o    (ctrl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctrl.load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load_out) begin
      m_id_q   <= ctrl.sel_head ? head_id : IDF_W'(IDX_W'(new_id));
      m_kind_q <= ctrl.kind;
      m_last_q <= ctrl.last;
    end
  end

  assign s_axis_tready = ctrl.s_ready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_id_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tlast  = m_last_q;

  // occupied slots always form a block starting at the head
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec + 1'b1) & valid_vec) == '0)
    else $error("queue slots not contiguous");

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready) |-> !ctrl.load_out)
    else $error("output overwritten while stalled");

  // rejection only when the tail slot is taken
  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.load_out && ctrl.kind == KIND_REJECTED) |-> valid_w[QUEUE_DEPTH-1])
    else $error("rejected with free slot");

  // a pop always removes a due head
  a_pop_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.shift == SH_POP) |-> (keep_w[0] && ctrl.state == ST_DRAIN))
    else $error("pop without due head");

  // a woken result that is not last leaves a due head behind
  a_more_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.shift == SH_POP && !ctrl.last) |=> (ctrl.state == ST_DRAIN && keep_w[0]))
    else $error("drain ended early");

endmodule
